// ----- src/ebcx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebcx_pkg
// Shared constants for the eight-bit CPU subset execute block: field widths,
// stream packing, flag positions, opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package ebcx_pkg;

  localparam int DATA_W          = 8;
  localparam int ADDR_W          = 14;
  localparam int FLAG_W          = 4;
  localparam int STACK_DEPTH_DEF = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_FIELD_W = ADDR_W + 4 * DATA_W + FLAG_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int FL_C = 0;
  localparam int FL_P = 1;
  localparam int FL_Z = 2;
  localparam int FL_S = 3;

  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [DATA_W-1:0] OP_HLT0 = 8'h00;
  localparam logic [DATA_W-1:0] OP_HLT1 = 8'h01;
  localparam logic [DATA_W-1:0] OP_RLC  = 8'h02;
  localparam logic [DATA_W-1:0] OP_RFC  = 8'h03;
  localparam logic [DATA_W-1:0] OP_ADI  = 8'h04;
  localparam logic [DATA_W-1:0] OP_RST0 = 8'h05;
  localparam logic [DATA_W-1:0] OP_LAI  = 8'h06;
  localparam logic [DATA_W-1:0] OP_RET0 = 8'h07;
  localparam logic [DATA_W-1:0] OP_INB  = 8'h08;
  localparam logic [DATA_W-1:0] OP_DCB  = 8'h09;
  localparam logic [DATA_W-1:0] OP_RRC  = 8'h0a;
  localparam logic [DATA_W-1:0] OP_RFZ  = 8'h0b;
  localparam logic [DATA_W-1:0] OP_ACI  = 8'h0c;
  localparam logic [DATA_W-1:0] OP_RST1 = 8'h0d;
  localparam logic [DATA_W-1:0] OP_LBI  = 8'h0e;
  localparam logic [DATA_W-1:0] OP_RET1 = 8'h0f;
  localparam logic [DATA_W-1:0] OP_LHI  = 8'h2e;
  localparam logic [DATA_W-1:0] OP_LLI  = 8'h36;
  localparam logic [DATA_W-1:0] OP_LAM  = 8'hc7;

  localparam logic [ADDR_W-1:0] RST0_TARGET = 14'h0000;
  localparam logic [ADDR_W-1:0] RST1_TARGET = 14'h0008;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ACC   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_BREG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_HREG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LREG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_FLAGS = 3'd5;

endpackage : ebcx_pkg
`default_nettype wire

// ----- src/eight_bit_cpu_subset_execute.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eight_bit_cpu_subset_execute
// Executes one instruction of the supported subset, or a restart, per item.
// The result item becomes valid in the cycle after the input item is accepted.
// Throughput: one item per cycle unless the output stalls; architectural state and the
//   output register are both updated at the accept edge, so a new item may follow at once.
// The single output register frees up in the cycle its item is taken.
// Reset (synchronous): registers, flags, halt mark and the stack all clear.
// ----------------------------------------------------------------------------
module eight_bit_cpu_subset_execute
  import ebcx_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // opcode[7:0], immediate[15:8], mem_data[23:16]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic                   s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // next_pc[13:0], acc[21:14], breg[29:22], hreg[37:30], lreg[45:38],
  // carry_out[46], parity_out[47], zero_out[48], sign_out[49],
  // halted[50], unknown_op[51], zero pad above
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DATA_W-1:0] init_acc, init_breg, init_hreg, init_lreg;
  logic [ADDR_W-1:0] init_pc;
  logic [FLAG_W-1:0] init_flags;

  logic [DATA_W-1:0] acc_reg, b_reg, h_reg, l_reg;
  logic [FLAG_W-1:0] flag_bits;
  logic              halt_mark;
  logic [ADDR_W-1:0] stack [STACK_DEPTH];

  logic [DATA_W-1:0] acc_next, b_next, h_next, l_next;
  logic [FLAG_W-1:0] flag_next;
  logic              halt_next;
  logic              unk_next;
  logic [ADDR_W-1:0] stack_next [STACK_DEPTH];

  logic              out_valid;
  logic [OUT_TDATA_W-1:0] out_data;

  logic              in_accept;
  logic [DATA_W-1:0] opcode, immediate, mem_data;
  logic [ADDR_W-1:0] pc1, pc2;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] b_inc, b_dec;

  assign opcode    = s_axis_tdata[7:0];
  assign immediate = s_axis_tdata[15:8];
  assign mem_data  = s_axis_tdata[23:16];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;

  assign pc1   = stack[0] + ADDR_W'(1);
  assign pc2   = stack[0] + ADDR_W'(2);
  assign b_inc = b_reg + DATA_W'(1);
  assign b_dec = b_reg - DATA_W'(1);
  assign sum   = {1'b0, acc_reg} + {1'b0, immediate}
               + ((opcode == OP_ACI) ? (DATA_W+1)'(flag_bits[FL_C]) : '0);

  function automatic logic [FLAG_W-1:0] pzs_flags(input logic [DATA_W-1:0] r,
                                                   input logic c);
    logic [FLAG_W-1:0] f;
    f       = '0;
    f[FL_C] = c;
    f[FL_P] = ~^r;
    f[FL_Z] = (r == '0);
    f[FL_S] = r[DATA_W-1];
    return f;
  endfunction

  always_comb begin
    acc_next  = acc_reg;
    b_next    = b_reg;
    h_next    = h_reg;
    l_next    = l_reg;
    flag_next = flag_bits;
    halt_next = halt_mark;
    unk_next  = 1'b0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_next[i] = stack[i];
    end
    if (s_axis_tuser == CMD_RESTART) begin
      acc_next  = init_acc;
      b_next    = init_breg;
      h_next    = init_hreg;
      l_next    = init_lreg;
      flag_next = init_flags;
      halt_next = 1'b0;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stack_next[i] = '0;
      end
      stack_next[0] = init_pc;
    end else if (!halt_mark) begin
      stack_next[0] = pc1;
      case (opcode)
        OP_HLT0, OP_HLT1: begin
          halt_next = 1'b1;
        end
        OP_RLC: begin
          flag_next[FL_C] = acc_reg[DATA_W-1];
          acc_next        = {acc_reg[DATA_W-2:0], acc_reg[DATA_W-1]};
        end
        OP_RRC: begin
          flag_next[FL_C] = acc_reg[0];
          acc_next        = {acc_reg[0], acc_reg[DATA_W-1:1]};
        end
        OP_RFC, OP_RFZ, OP_RET0, OP_RET1: begin
          if ((opcode == OP_RET0) || (opcode == OP_RET1) ||
              ((opcode == OP_RFC) && !flag_bits[FL_C]) ||
              ((opcode == OP_RFZ) && !flag_bits[FL_Z])) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
              stack_next[i] = stack[i+1];
            end
          end
        end
        OP_ADI, OP_ACI: begin
          acc_next      = sum[DATA_W-1:0];
          flag_next     = pzs_flags(sum[DATA_W-1:0], sum[DATA_W]);
          stack_next[0] = pc2;
        end
        OP_RST0, OP_RST1: begin
          for (int i = 2; i < STACK_DEPTH; i++) begin
            stack_next[i] = stack[i-1];
          end
          stack_next[1] = pc1;
          stack_next[0] = (opcode == OP_RST1) ? RST1_TARGET : RST0_TARGET;
        end
        OP_LAI: begin
          acc_next      = immediate;
          stack_next[0] = pc2;
        end
        OP_LBI: begin
          b_next        = immediate;
          stack_next[0] = pc2;
        end
        OP_LHI: begin
          h_next        = immediate;
          stack_next[0] = pc2;
        end
        OP_LLI: begin
          l_next        = immediate;
          stack_next[0] = pc2;
        end
        OP_LAM: begin
          acc_next = mem_data;
        end
        OP_INB: begin
          b_next    = b_inc;
          flag_next = pzs_flags(b_inc, flag_bits[FL_C]);
        end
        OP_DCB: begin
          b_next    = b_dec;
          flag_next = pzs_flags(b_dec, flag_bits[FL_C]);
        end
        default: begin
          unk_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_acc   <= '0;
      init_breg  <= '0;
      init_hreg  <= '0;
      init_lreg  <= '0;
      init_pc    <= '0;
      init_flags <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INIT_ACC:   init_acc   <= cfg_data[DATA_W-1:0];
        CFG_INIT_BREG:  init_breg  <= cfg_data[DATA_W-1:0];
        CFG_INIT_HREG:  init_hreg  <= cfg_data[DATA_W-1:0];
        CFG_INIT_LREG:  init_lreg  <= cfg_data[DATA_W-1:0];
        CFG_INIT_PC:    init_pc    <= cfg_data[ADDR_W-1:0];
        CFG_INIT_FLAGS: init_flags <= cfg_data[FLAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_reg   <= '0;
      b_reg     <= '0;
      h_reg     <= '0;
      l_reg     <= '0;
      flag_bits <= '0;
      halt_mark <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack[i] <= '0;
      end
    end else if (in_accept) begin
      acc_reg   <= acc_next;
      b_reg     <= b_next;
      h_reg     <= h_next;
      l_reg     <= l_next;
      flag_bits <= flag_next;
      halt_mark <= halt_next;
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stack[i] <= stack_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= OUT_TDATA_W'({unk_next, halt_next,
                                flag_next[FL_S], flag_next[FL_Z],
                                flag_next[FL_P], flag_next[FL_C],
                                l_next, h_next, b_next, acc_next,
                                stack_next[0]});
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  a_restart_clears_halt: assert property (@(posedge clk) disable iff (rst)
    in_accept && (s_axis_tuser == CMD_RESTART) |=> !halt_mark)
    else $error("restart left halt mark set");

  a_halt_freezes: assert property (@(posedge clk) disable iff (rst)
    in_accept && halt_mark && (s_axis_tuser == CMD_EXEC)
    |=> $stable(acc_reg) && $stable(b_reg) && $stable(flag_bits)
        && (stack[0] == $past(stack[0])))
    else $error("halted execute changed state");

  a_halt_not_unknown: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_data[50] |-> !out_data[51])
    else $error("halted result flagged unknown opcode");

  a_rst_push: assert property (@(posedge clk) disable iff (rst)
    in_accept && !halt_mark && (s_axis_tuser == CMD_EXEC) && (opcode == OP_RST1)
    |=> (stack[0] == RST1_TARGET) && (stack[1] == $past(pc1)))
    else $error("restart call did not push return address");

endmodule : eight_bit_cpu_subset_execute
`default_nettype wire

// ----- bench/tb_eight_bit_cpu_subset_execute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_cpu_subset_execute
// Streams execute and restart commands into the CPU subset block. Each
// accepted command is run through a local machine model (registers, flags,
// halt mark, return stack). Every result item is compared field by field with
// the oldest predicted machine state. A directed program comes first, then
// random instruction streams under several restart settings, with random
// idling on both sides, a steady stretch, and one long output back-pressure.
// ----------------------------------------------------------------------------
module tb_eight_bit_cpu_subset_execute;
  import ebcx_pkg::*;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] mem_data;
    logic [DATA_W-1:0] immediate;
    logic [DATA_W-1:0] opcode;
  } cpu_cmd_t;

  // Packed from the top down, so next_pc lands in the lowest bits.
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
    logic                               unknown_op;
    logic                               halted;
    logic                               sign_out;
    logic                               zero_out;
    logic                               parity_out;
    logic                               carry_out;
    logic [DATA_W-1:0]                  lreg;
    logic [DATA_W-1:0]                  hreg;
    logic [DATA_W-1:0]                  breg;
    logic [DATA_W-1:0]                  acc;
    logic [ADDR_W-1:0]                  next_pc;
  } cpu_state_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // restart values as last written
  logic [DATA_W-1:0] boot_acc = '0;
  logic [DATA_W-1:0] boot_b = '0;
  logic [DATA_W-1:0] boot_h = '0;
  logic [DATA_W-1:0] boot_l = '0;
  logic [ADDR_W-1:0] boot_pc = '0;
  logic [FLAG_W-1:0] boot_flags = '0;

  // machine model
  logic [DATA_W-1:0] m_acc = '0;
  logic [DATA_W-1:0] m_b = '0;
  logic [DATA_W-1:0] m_h = '0;
  logic [DATA_W-1:0] m_l = '0;
  logic [FLAG_W-1:0] m_flags = '0;
  logic [ADDR_W-1:0] m_stack [STACK_DEPTH_DEF];
  logic              m_halt = 1'b0;

  cpu_cmd_t    pending_q [$];
  cpu_state_t  expected_q [$];
  cpu_cmd_t    next_cmd;
  cpu_state_t  want;
  cpu_state_t  seen;

  int unsigned items_queued = 0;
  int unsigned items_matched = 0;
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  logic        steady = 1'b0;
  logic        stall_req = 1'b0;
  logic        stall_taken = 1'b0;

  eight_bit_cpu_subset_execute u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // {sign, zero, parity} of a result byte
  function automatic logic [2:0] szp_of(input logic [DATA_W-1:0] r);
    return {r[7], r == '0, ~(^r)};
  endfunction

  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(255));
  endfunction

  task automatic run_machine(input logic cmd, input logic [DATA_W-1:0] op,
                             input logic [DATA_W-1:0] imm,
                             input logic [DATA_W-1:0] md);
    logic [ADDR_W-1:0] pc1;
    logic [ADDR_W-1:0] pc2;
    logic [DATA_W:0]   sum;
    logic              unk;
    logic              taken;
    cpu_state_t        r;
    unk = 1'b0;
    if (cmd == CMD_RESTART) begin
      m_acc = boot_acc;
      m_b = boot_b;
      m_h = boot_h;
      m_l = boot_l;
      m_flags = boot_flags;
      for (int i = 0; i < STACK_DEPTH_DEF; i++) m_stack[i] = '0;
      m_stack[0] = boot_pc;
      m_halt = 1'b0;
    end else if (!m_halt) begin
      pc1 = m_stack[0] + ADDR_W'(1);
      pc2 = m_stack[0] + ADDR_W'(2);
      m_stack[0] = pc1;
      case (op)
        OP_HLT0, OP_HLT1: m_halt = 1'b1;
        OP_RLC: begin
          m_flags[FL_C] = m_acc[7];
          m_acc = {m_acc[6:0], m_acc[7]};
        end
        OP_RRC: begin
          m_flags[FL_C] = m_acc[0];
          m_acc = {m_acc[0], m_acc[7:1]};
        end
        OP_RFC, OP_RFZ, OP_RET0, OP_RET1: begin
          taken = (op == OP_RFC) ? !m_flags[FL_C] :
                  (op == OP_RFZ) ? !m_flags[FL_Z] : 1'b1;
          if (taken)
            for (int i = 0; i < STACK_DEPTH_DEF - 1; i++) m_stack[i] = m_stack[i + 1];
        end
        OP_ADI, OP_ACI: begin
          sum = {1'b0, m_acc} + {1'b0, imm}
              + {{DATA_W{1'b0}}, ((op == OP_ACI) ? m_flags[FL_C] : 1'b0)};
          m_acc = sum[DATA_W-1:0];
          m_flags[FL_S:FL_P] = szp_of(m_acc);
          m_flags[FL_C] = sum[DATA_W];
          m_stack[0] = pc2;
        end
        OP_RST0, OP_RST1: begin
          for (int i = STACK_DEPTH_DEF - 1; i > 0; i--) m_stack[i] = m_stack[i - 1];
          m_stack[0] = (op == OP_RST0) ? RST0_TARGET : RST1_TARGET;
        end
        OP_LAI: begin
          m_acc = imm;
          m_stack[0] = pc2;
        end
        OP_LBI: begin
          m_b = imm;
          m_stack[0] = pc2;
        end
        OP_LHI: begin
          m_h = imm;
          m_stack[0] = pc2;
        end
        OP_LLI: begin
          m_l = imm;
          m_stack[0] = pc2;
        end
        OP_LAM: m_acc = md;
        OP_INB, OP_DCB: begin
          m_b = (op == OP_INB) ? m_b + DATA_W'(1) : m_b - DATA_W'(1);
          m_flags[FL_S:FL_P] = szp_of(m_b);
        end
        default: unk = 1'b1;
      endcase
    end
    r = '0;
    r.next_pc = m_stack[0];
    r.acc = m_acc;
    r.breg = m_b;
    r.hreg = m_h;
    r.lreg = m_l;
    r.carry_out = m_flags[FL_C];
    r.parity_out = m_flags[FL_P];
    r.zero_out = m_flags[FL_Z];
    r.sign_out = m_flags[FL_S];
    r.halted = m_halt;
    r.unknown_op = unk;
    expected_q.push_back(r);
  endtask

  // input side: predict on accept, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        run_machine(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
          next_cmd = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {next_cmd.mem_data, next_cmd.immediate, next_cmd.opcode};
          s_axis_tuser <= next_cmd.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // output side: check results, drive ready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("next_pc", 16'(want.next_pc), 16'(seen.next_pc));
          check_field("acc", 16'(want.acc), 16'(seen.acc));
          check_field("breg", 16'(want.breg), 16'(seen.breg));
          check_field("hreg", 16'(want.hreg), 16'(seen.hreg));
          check_field("lreg", 16'(want.lreg), 16'(seen.lreg));
          check_field("carry_out", 16'(want.carry_out), 16'(seen.carry_out));
          check_field("parity_out", 16'(want.parity_out), 16'(seen.parity_out));
          check_field("zero_out", 16'(want.zero_out), 16'(seen.zero_out));
          check_field("sign_out", 16'(want.sign_out), 16'(seen.sign_out));
          check_field("halted", 16'(want.halted), 16'(seen.halted));
          check_field("unknown_op", 16'(want.unknown_op), 16'(seen.unknown_op));
          check_field("pad", 16'(want.pad), 16'(seen.pad));
          items_matched++;
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (stall_req && !stall_taken) begin
        m_axis_tready <= 1'b0;
        hold_left <= 79;
        stall_taken <= 1'b1;
      end else begin
        m_axis_tready <= steady || $urandom_range(99) >= 16;
      end
    end
  end

  task automatic queue_item(input logic cmd, input logic [DATA_W-1:0] op,
                            input logic [DATA_W-1:0] imm,
                            input logic [DATA_W-1:0] md);
    cpu_cmd_t c;
    c.cmd = cmd;
    c.opcode = op;
    c.immediate = imm;
    c.mem_data = md;
    pending_q.push_back(c);
    items_queued++;
  endtask

  task automatic queue_exec(input logic [DATA_W-1:0] op);
    queue_item(CMD_EXEC, op, rand_byte(), rand_byte());
  endtask

  function automatic logic [DATA_W-1:0] pick_op();
    case ($urandom_range(16))
      0: return OP_RLC;
      1: return OP_RFC;
      2: return OP_ADI;
      3: return OP_RST0;
      4: return OP_LAI;
      5: return OP_RET0;
      6: return OP_INB;
      7: return OP_DCB;
      8: return OP_RRC;
      9: return OP_RFZ;
      10: return OP_ACI;
      11: return OP_RST1;
      12: return OP_LBI;
      13: return OP_RET1;
      14: return OP_LHI;
      15: return OP_LLI;
      default: return OP_LAM;
    endcase
  endfunction

  // Mostly running code, with call chains deeper than the stack, rare
  // halts followed by restarts, and raw opcode bytes.
  task automatic queue_program(input int unsigned n);
    int unsigned done;
    int unsigned k;
    done = 0;
    queue_item(CMD_RESTART, rand_byte(), rand_byte(), rand_byte());
    while (done < n) begin
      k = $urandom_range(99);
      if (k < 3) begin
        queue_item(CMD_RESTART, rand_byte(), rand_byte(), rand_byte());
        done++;
      end else if (k < 5) begin
        queue_exec($urandom_range(1) ? OP_HLT1 : OP_HLT0);
        repeat ($urandom_range(2)) queue_exec(rand_byte());
        queue_item(CMD_RESTART, rand_byte(), rand_byte(), rand_byte());
        done += 2;
      end else if (k < 8) begin
        k = $urandom_range(1, 10);
        repeat (k) queue_exec($urandom_range(1) ? OP_RST1 : OP_RST0);
        repeat (k) begin
          case ($urandom_range(3))
            0: queue_exec(OP_RET0);
            1: queue_exec(OP_RET1);
            2: queue_exec(OP_RFC);
            default: queue_exec(OP_RFZ);
          endcase
        end
        done += 2 * k;
      end else if (k < 14) begin
        queue_exec(rand_byte());
        done++;
      end else begin
        queue_exec(pick_op());
        done++;
      end
    end
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INIT_ACC:   boot_acc = val[DATA_W-1:0];
      CFG_INIT_BREG:  boot_b = val[DATA_W-1:0];
      CFG_INIT_HREG:  boot_h = val[DATA_W-1:0];
      CFG_INIT_LREG:  boot_l = val[DATA_W-1:0];
      CFG_INIT_PC:    boot_pc = val[ADDR_W-1:0];
      CFG_INIT_FLAGS: boot_flags = val[FLAG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_boot(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                          input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] l,
                          input logic [ADDR_W-1:0] pc, input logic [FLAG_W-1:0] fl);
    cfg_put(CFG_INIT_ACC, CFG_DATA_W'(a));
    cfg_put(CFG_INIT_BREG, CFG_DATA_W'(b));
    cfg_put(CFG_INIT_HREG, CFG_DATA_W'(h));
    cfg_put(CFG_INIT_LREG, CFG_DATA_W'(l));
    cfg_put(CFG_INIT_PC, CFG_DATA_W'(pc));
    cfg_put(CFG_INIT_FLAGS, CFG_DATA_W'(fl));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_matched != items_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed program
    set_boot(8'h80, 8'h01, 8'hff, 8'h00, 14'h3ffe, 4'h0);
    queue_item(CMD_RESTART, 8'h00, 8'h00, 8'h00);
    queue_item(CMD_EXEC, OP_ADI, 8'h80, 8'h00);   // pc wraps, carry out, zero
    queue_item(CMD_EXEC, OP_ACI, 8'hff, 8'hff);   // carry in
    queue_exec(OP_RFC);                            // not taken, carry set
    queue_item(CMD_EXEC, OP_LAI, 8'hff, 8'h00);
    queue_exec(OP_RLC);
    queue_exec(OP_RRC);
    queue_item(CMD_EXEC, OP_LBI, 8'hff, 8'h00);
    queue_exec(OP_INB);                            // wraps to zero
    queue_exec(OP_DCB);                            // back to all ones
    queue_exec(OP_RFZ);                            // taken, zero clear
    queue_item(CMD_EXEC, OP_LHI, 8'h00, 8'hff);
    queue_item(CMD_EXEC, OP_LLI, 8'hff, 8'h00);
    queue_item(CMD_EXEC, OP_LAM, 8'h00, 8'ha5);
    queue_exec(OP_RST1);
    queue_exec(OP_RST0);
    queue_exec(OP_RET0);
    queue_item(CMD_EXEC, OP_ADI, 8'h01, 8'h00);   // carry clear
    queue_exec(OP_RFC);                            // taken
    queue_exec(OP_RET1);
    queue_item(CMD_EXEC, 8'hff, 8'hff, 8'hff);    // unknown opcode
    queue_exec(OP_HLT0);
    queue_item(CMD_EXEC, OP_ADI, 8'h55, 8'h00);   // ignored while halted
    queue_item(CMD_RESTART, 8'hff, 8'hff, 8'hff);
    queue_exec(OP_HLT1);
    queue_item(CMD_RESTART, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // all-zero restart values, no idling on either side
    set_boot('0, '0, '0, '0, '0, '0);
    @(posedge clk);
    steady <= 1'b1;
    queue_program(200);
    wait_drained();
    steady <= 1'b0;

    // all-ones restart values, with a long output hold-off
    set_boot(8'hff, 8'hff, 8'hff, 8'hff, 14'h3fff, 4'hf);
    queue_program(240);
    @(posedge clk);
    stall_req <= 1'b1;
    wait_drained();

    repeat (2) begin
      set_boot(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
               ADDR_W'($urandom_range(16383)), FLAG_W'($urandom_range(15)));
      queue_program(120);
      wait_drained();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0)
      $display("eight_bit_cpu_subset_execute test passed");
    else
      $display("eight_bit_cpu_subset_execute test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("eight_bit_cpu_subset_execute test failed");
    $finish;
  end

endmodule
